/* rtl/dtdm_pkg.sv */
// dtdm_pkg: shared types, register codes and helpers for the turn duty mixer
// no dependencies; compile first

package dtdm_pkg;

  // configuration register indexes
  localparam logic [7:0] RegEncoderGain    = 8'd0;
  localparam logic [7:0] RegYawGain        = 8'd1;
  localparam logic [7:0] RegYawIntegralGain = 8'd2;
  localparam logic [7:0] RegDutyCeiling    = 8'd3;

  localparam logic [15:0] EncoderGainReset    = 16'd256;
  localparam logic [15:0] YawGainReset        = 16'd256;
  localparam logic [15:0] YawIntegralGainReset = 16'd0;
  localparam logic [15:0] DutyCeilingReset    = 16'd16320;

  // +-220.0 in Q10.6
  localparam logic signed [38:0] TermLimit = 39'sd14080;
  // 1.0 in Q1.15
  localparam logic [15:0] ScaleOne = 16'h8000;
  // quotient bits of the scale division
  localparam int DivSteps = 15;

  // item in flight between the term stages and the scale stages
  typedef struct packed {
    logic [15:0]        left_duty;
    logic [15:0]        right_duty;
    logic signed [14:0] yaw;
    logic signed [14:0] diff;
    logic               need;
    logic [15:0]        max_duty;
    logic [15:0]        rem;
    logic [14:0]        quot;
  } mix_t;

  function automatic logic signed [14:0] clamp_term(input logic signed [38:0] v);
    logic signed [14:0] r;
    if (v < -TermLimit) r = -TermLimit[14:0];
    else if (v > TermLimit) r = TermLimit[14:0];
    else r = v[14:0];
    return r;
  endfunction

endpackage

/* rtl/dtdm_if.sv */
// dtdm channel interfaces: input items, result items, register writes
// no dependencies

interface dtdm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] base_duty;
  logic signed [15:0] balance_error;
  logic signed [15:0] yaw_error;
  logic signed [19:0] yaw_accum;
  logic               turn_left;
  modport source(output valid, base_duty, balance_error, yaw_error, yaw_accum, turn_left,
                 input ready);
  modport sink(input valid, base_duty, balance_error, yaw_error, yaw_accum, turn_left,
               output ready);
endinterface

interface dtdm_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        left_duty;
  logic [15:0]        right_duty;
  logic signed [14:0] yaw_part;
  logic signed [14:0] balance_part;
  logic [15:0]        scale_used;
  modport source(output valid, left_duty, right_duty, yaw_part, balance_part, scale_used,
                 input ready);
  modport sink(input valid, left_duty, right_duty, yaw_part, balance_part, scale_used,
               output ready);
endinterface

interface dtdm_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/differential_turn_duty_mixer_top.sv */
// differential_turn_duty_mixer_top: register file and the mixer pipeline
// depends on dtdm_pkg, dtdm_if, dtdm_terms, dtdm_div, dtdm_scale

// the mixer takes one item per clock unless stalled and runs it through two
// term stages, fifteen divider stages and two scale stages; the scale
// division resolves one quotient bit per stage. each stage holds only while
// its successor is full and stalled, so bubbles close up and the input keeps
// accepting while a result waits at the output, until all stages are full.
// register writes take effect at once and are meant for an idle pipeline.

module differential_turn_duty_mixer_top import dtdm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  dtdm_in_if.sink    in_ch,
  dtdm_out_if.source out_ch,
  dtdm_cfg_if.sink   cfg_ch
);

  logic [15:0] encoder_gain_r, yaw_gain_r, yaw_integral_gain_r, duty_ceiling_r;
  logic        t_valid, t_ready, d_valid, d_ready;
  mix_t        t_item, d_item;

  // register writes are always taken; unknown indexes are dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encoder_gain_r      <= EncoderGainReset;
      yaw_gain_r          <= YawGainReset;
      yaw_integral_gain_r <= YawIntegralGainReset;
      duty_ceiling_r      <= DutyCeilingReset;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        RegEncoderGain:     encoder_gain_r      <= cfg_ch.data;
        RegYawGain:         yaw_gain_r          <= cfg_ch.data;
        RegYawIntegralGain: yaw_integral_gain_r <= cfg_ch.data;
        RegDutyCeiling:     duty_ceiling_r      <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // terms, mix and floor
  dtdm_terms u_terms (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .base_duty         (in_ch.base_duty),
    .balance_error     (in_ch.balance_error),
    .yaw_error         (in_ch.yaw_error),
    .yaw_accum         (in_ch.yaw_accum),
    .turn_left         (in_ch.turn_left),
    .encoder_gain      (encoder_gain_r),
    .yaw_gain          (yaw_gain_r),
    .yaw_integral_gain (yaw_integral_gain_r),
    .duty_ceiling      (duty_ceiling_r),
    .dn_valid          (t_valid),
    .dn_ready          (t_ready),
    .dn_item           (t_item)
  );

  // scale = ceiling / max duty in q1.15
  dtdm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (t_valid),
    .up_ready (t_ready),
    .up_item  (t_item),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn_item  (d_item)
  );

  // apply the scale and hold the result
  dtdm_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (d_valid),
    .up_ready     (d_ready),
    .up_item      (d_item),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .left_duty    (out_ch.left_duty),
    .right_duty   (out_ch.right_duty),
    .yaw_part     (out_ch.yaw_part),
    .balance_part (out_ch.balance_part),
    .scale_used   (out_ch.scale_used)
  );

  // scale never exceeds one
  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.scale_used <= ScaleOne)
    else $error("scale above one");

  // a scaled item never exceeds the ceiling on either wheel
  a_scaled_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.scale_used != ScaleOne) |->
      (out_ch.left_duty <= duty_ceiling_r && out_ch.right_duty <= duty_ceiling_r))
    else $error("scaled duty above ceiling");

  // pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

/* rtl/dtdm_terms.sv */
// dtdm_terms: gain products, yaw and differential terms, wheel duties
// depends on dtdm_pkg

module dtdm_terms import dtdm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] base_duty,
  input  logic signed [15:0] balance_error,
  input  logic signed [15:0] yaw_error,
  input  logic signed [19:0] yaw_accum,
  input  logic               turn_left,
  input  logic [15:0]        encoder_gain,
  input  logic [15:0]        yaw_gain,
  input  logic [15:0]        yaw_integral_gain,
  input  logic [15:0]        duty_ceiling,
  output logic               dn_valid,
  input  logic               dn_ready,
  output mix_t               dn_item
);

  logic               v1_r, v2_r;
  logic               en1, en2;
  logic signed [32:0] bal_p_r, bal_p_nxt;
  logic signed [33:0] yp_p_r, yp_p_nxt;
  logic signed [37:0] yi_p_r, yi_p_nxt;
  logic signed [15:0] base_r;
  logic signed [16:0] yerr_n;
  logic signed [20:0] yacc_n;
  logic signed [38:0] yaw_sum, bal_ext;
  logic signed [14:0] yaw_c, diff_c;
  logic signed [17:0] bw, dl, dr;
  logic [15:0]        dl_u, dr_u, mx;
  mix_t               item_r, item_nxt;

  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // stage 1: products, yaw errors negated for right turns
  always_comb begin
    yerr_n    = turn_left ? 17'(yaw_error) : -17'(yaw_error);
    yacc_n    = turn_left ? 21'(yaw_accum) : -21'(yaw_accum);
    bal_p_nxt = $signed({1'b0, encoder_gain}) * 33'(balance_error);
    yp_p_nxt  = $signed({1'b0, yaw_gain}) * 34'(yerr_n);
    yi_p_nxt  = $signed({1'b0, yaw_integral_gain}) * 38'(yacc_n);
  end

  // stage 2: shift, clamp, mix and floor
  always_comb begin
    yaw_sum = 39'(yp_p_r) + 39'(yi_p_r);
    bal_ext = 39'(bal_p_r);
    yaw_c   = clamp_term(yaw_sum >>> 8);
    diff_c  = clamp_term(bal_ext >>> 2);
    bw      = 18'(base_r) + 18'(yaw_c);
    dl      = bw - 18'(diff_c);
    dr      = bw + 18'(diff_c);
    dl_u    = dl[17] ? 16'd0 : dl[15:0];
    dr_u    = dr[17] ? 16'd0 : dr[15:0];
    mx      = (dl_u > dr_u) ? dl_u : dr_u;
    item_nxt.left_duty  = dl_u;
    item_nxt.right_duty = dr_u;
    item_nxt.yaw        = yaw_c;
    item_nxt.diff       = diff_c;
    item_nxt.need       = mx > duty_ceiling;
    item_nxt.max_duty   = mx;
    item_nxt.rem        = duty_ceiling;
    item_nxt.quot       = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      bal_p_r <= bal_p_nxt;
      yp_p_r  <= yp_p_nxt;
      yi_p_r  <= yi_p_nxt;
      base_r  <= base_duty;
    end
    if (en2) item_r <= item_nxt;
  end

  assign dn_valid = v2_r;
  assign dn_item  = item_r;

endmodule

/* rtl/dtdm_div.sv */
// dtdm_div: pipelined restoring divider, ceiling * 2^15 / max duty, one bit a stage
// depends on dtdm_pkg

module dtdm_div import dtdm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  mix_t up_item,
  output logic dn_valid,
  input  logic dn_ready,
  output mix_t dn_item
);

  mix_t st_r [DivSteps];
  logic v_r  [DivSteps];
  logic en   [DivSteps];

  function automatic mix_t div_step(input mix_t a);
    mix_t        r;
    logic [16:0] r2;
    logic        ge;
    r  = a;
    r2 = {a.rem, 1'b0};
    ge = r2 >= {1'b0, a.max_duty};
    r.rem  = ge ? 16'(r2 - {1'b0, a.max_duty}) : r2[15:0];
    r.quot = {a.quot[13:0], ge};
    return r;
  endfunction

  always_comb begin
    en[DivSteps-1] = !v_r[DivSteps-1] || dn_ready;
    for (int k = DivSteps - 2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign up_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DivSteps; k++) v_r[k] <= 1'b0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < DivSteps; k++) if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) st_r[0] <= div_step(up_item);
    for (int k = 1; k < DivSteps; k++) if (en[k]) st_r[k] <= div_step(st_r[k-1]);
  end

  assign dn_valid = v_r[DivSteps-1];
  assign dn_item  = st_r[DivSteps-1];

endmodule

/* rtl/dtdm_scale.sv */
// dtdm_scale: scale products and the result register
// depends on dtdm_pkg

module dtdm_scale import dtdm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  mix_t               up_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        left_duty,
  output logic [15:0]        right_duty,
  output logic signed [14:0] yaw_part,
  output logic signed [14:0] balance_part,
  output logic [15:0]        scale_used
);

  logic               va_r, vb_r, ena, enb;
  logic [15:0]        scale;
  logic [31:0]        pl_r, pr_r;
  logic signed [31:0] py_r, pd_r;
  logic [15:0]        sa_r;
  logic [15:0]        left_r, right_r, scale_r;
  logic signed [14:0] yaw_r, diff_r;

  assign enb      = !vb_r || out_ready;
  assign ena      = !va_r || enb;
  assign up_ready = ena;

  // unscaled items take the product by one, which passes them unchanged
  assign scale = up_item.need ? {1'b0, up_item.quot} : ScaleOne;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ena) va_r <= up_valid;
      if (enb) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      pl_r <= 32'(up_item.left_duty) * 32'(scale);
      pr_r <= 32'(up_item.right_duty) * 32'(scale);
      py_r <= 32'(up_item.yaw) * $signed({16'd0, scale});
      pd_r <= 32'(up_item.diff) * $signed({16'd0, scale});
      sa_r <= scale;
    end
    if (enb) begin
      left_r  <= pl_r[30:15];
      right_r <= pr_r[30:15];
      yaw_r   <= py_r[29:15];
      diff_r  <= pd_r[29:15];
      scale_r <= sa_r;
    end
  end

  assign out_valid    = vb_r;
  assign left_duty    = left_r;
  assign right_duty   = right_r;
  assign yaw_part     = yaw_r;
  assign balance_part = diff_r;
  assign scale_used   = scale_r;

endmodule
